// ----- sv/mva_pkg.sv -----
package mva_pkg;

    localparam int VOICES_DEF = 8;

    localparam logic [1:0] MODE_NOTE_OFF = 2'd0;
    localparam logic [1:0] MODE_NOTE_ON  = 2'd1;

    localparam logic [3:0] DRUM_CHANNEL  = 4'd9;

    typedef enum logic [2:0] {
        ACT_NONE       = 3'd0,
        ACT_GATE_ON    = 3'd1,
        ACT_GATE_OFF   = 3'd2,
        ACT_DRUM_START = 3'd3,
        ACT_DRUM_STOP  = 3'd4,
        ACT_NO_VOICE   = 3'd5,
        ACT_NOT_HELD   = 3'd6
    } t_action;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

    // search request walking the voice cells
    typedef struct packed {
        logic       valid;
        logic       is_off;
        logic [6:0] note;
        logic       found;
    } t_tok;

endpackage

// ----- sv/mva_in_if.sv -----
interface mva_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [6:0] note;
    logic [6:0] velocity;

    modport source (output valid, mode, note, velocity, input ready);
    modport sink   (input valid, mode, note, velocity, output ready);
endinterface

// ----- sv/mva_out_if.sv -----
interface mva_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [2:0] voice_index;
    logic [6:0] note_out;
    logic [6:0] velocity_out;

    modport source (output valid, action, voice_index, note_out, velocity_out, input ready);
    modport sink   (input valid, action, voice_index, note_out, velocity_out, output ready);
endinterface

// ----- sv/mva_cfg_if.sv -----
interface mva_cfg_if;
    logic       valid;
    logic       ready;
    logic [3:0] channel_number;

    modport source (output valid, channel_number, input ready);
    modport sink   (input valid, channel_number, output ready);
endinterface

// ----- sv/mva_cell.sv -----
module mva_cell #(
    parameter int IDX   = 0,
    parameter int IDX_W = 3
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mva_pkg::t_tok      i_tok,
    input  logic [IDX_W-1:0]   i_idx,
    output mva_pkg::t_tok      o_tok,
    output logic [IDX_W-1:0]   o_idx
);
    import mva_pkg::*;

    logic             r_busy;
    logic [6:0]       r_key;
    t_tok             r_tok;
    logic [IDX_W-1:0] r_idx;

    logic w_hit;
    t_tok n_tok;

    always_comb begin
        w_hit = i_tok.valid && !i_tok.found &&
                (i_tok.is_off ? (r_busy && (r_key == i_tok.note)) : !r_busy);
        n_tok = i_tok;
        n_tok.found = i_tok.found | w_hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_tok.valid <= 1'b0;
        end else begin
            r_tok <= n_tok;
            if (w_hit) begin
                r_busy <= !i_tok.is_off;
            end
        end
    end

    // payload of the cell: key and index need no reset
    always_ff @(posedge i_clk) begin
        r_idx <= w_hit ? IDX_W'(IDX) : i_idx;
        if (w_hit && !i_tok.is_off) begin
            r_key <= i_tok.note;
        end
    end

    assign o_tok = r_tok;
    assign o_idx = r_idx;

endmodule

// ----- sv/midi_voice_allocator_core.sv -----
// MIDI voice allocator for one channel, first-free policy. Each request is one
// channel event (note off, note on, other) and yields exactly one result. On a
// melodic channel a note event launches a search that walks a row of VOICES
// voice cells, one cell per clock; the first free (note on) or first matching
// busy (note off / velocity zero) cell claims or frees itself. The result
// leaves the last cell into a pending register, and the next request is taken
// once that result has moved on into the output register. Drum-channel and
// ignored events skip the search and go into the pending register. A finished
// result waits in an output register, so a new request can be taken while it
// is stalled. The channel register is written through the config channel,
// which is always ready; write it only while the block is idle.
module midi_voice_allocator_core #(
    parameter int VOICES = mva_pkg::VOICES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mva_in_if.sink     i_req,
    mva_out_if.source  o_res,
    mva_cfg_if.sink    i_cfg
);
    import mva_pkg::*;

    localparam int IDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;

    t_state     r_state, n_state;
    logic [3:0] r_chan;
    logic [6:0] r_note;
    logic [6:0] r_vel;

    logic       r_pend_valid;
    t_action    r_pend_act;
    logic [2:0] r_pend_idx;
    logic [6:0] r_pend_note;
    logic [6:0] r_pend_vel;

    logic       r_out_valid;
    t_action    r_out_act;
    logic [2:0] r_out_idx;
    logic [6:0] r_out_note;
    logic [6:0] r_out_vel;

    t_tok             w_tok [VOICES+1];
    logic [IDX_W-1:0] w_idx [VOICES+1];

    logic    w_ready;
    logic    w_accept;
    logic    w_is_note;
    logic    w_drum;
    logic    w_launch;
    t_action w_imm_act;
    logic    w_out_free;
    t_tok    w_tail;
    t_action w_tail_act;

    assign w_accept  = i_req.valid && w_ready;
    assign w_is_note = (i_req.mode inside {MODE_NOTE_OFF, MODE_NOTE_ON});
    assign w_drum    = (r_chan == DRUM_CHANNEL);
    assign w_launch  = w_accept && w_is_note && !w_drum;
    assign w_tail    = w_tok[VOICES];

    // state machine: next state and ready
    always_comb begin
        n_state = r_state;
        w_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                w_ready = !r_pend_valid;
                if (w_launch) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_tail.valid) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // result for events that need no search
    always_comb begin
        if (!w_is_note) begin
            w_imm_act = ACT_NONE;
        end else if (i_req.mode == MODE_NOTE_OFF) begin
            w_imm_act = ACT_NONE;
        end else if (i_req.velocity == 7'd0) begin
            w_imm_act = ACT_DRUM_STOP;
        end else begin
            w_imm_act = ACT_DRUM_START;
        end
    end

    always_comb begin
        if (w_tail.is_off) begin
            w_tail_act = w_tail.found ? ACT_GATE_OFF : ACT_NOT_HELD;
        end else begin
            w_tail_act = w_tail.found ? ACT_GATE_ON : ACT_NO_VOICE;
        end
    end

    // launch request into the first cell
    assign w_tok[0] = '{
        valid:  w_launch,
        is_off: !((i_req.mode == MODE_NOTE_ON) && (i_req.velocity != 7'd0)),
        note:   i_req.note,
        found:  1'b0
    };
    assign w_idx[0] = '0;

    for (genvar g = 0; g < VOICES; g++) begin : g_cell
        mva_cell #(
            .IDX   (g),
            .IDX_W (IDX_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   (w_tok[g]),
            .i_idx   (w_idx[g]),
            .o_tok   (w_tok[g+1]),
            .o_idx   (w_idx[g+1])
        );
    end

    assign w_out_free = !r_out_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_chan       <= 4'd0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) begin
                r_chan <= i_cfg.channel_number;
            end
            // drain pending slot into the output register
            if (r_pend_valid && w_out_free) begin
                r_out_valid  <= 1'b1;
                r_pend_valid <= 1'b0;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if ((w_accept && !w_launch) || w_tail.valid) begin
                r_pend_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_note <= i_req.note;
            r_vel  <= i_req.velocity;
        end
        if (w_accept && !w_launch) begin
            r_pend_act  <= w_imm_act;
            r_pend_idx  <= 3'd0;
            r_pend_note <= (w_imm_act == ACT_NONE) ? 7'd0 : i_req.note;
            r_pend_vel  <= (w_imm_act == ACT_NONE) ? 7'd0 : i_req.velocity;
        end else if (w_tail.valid) begin
            r_pend_act  <= w_tail_act;
            r_pend_idx  <= 3'(w_idx[VOICES]);
            r_pend_note <= r_note;
            r_pend_vel  <= r_vel;
        end
        if (r_pend_valid && w_out_free) begin
            r_out_act  <= r_pend_act;
            r_out_idx  <= r_pend_idx;
            r_out_note <= r_pend_note;
            r_out_vel  <= r_pend_vel;
        end
    end

    assign i_req.ready        = w_ready;
    assign i_cfg.ready        = 1'b1;
    assign o_res.valid        = r_out_valid;
    assign o_res.action       = r_out_act;
    assign o_res.voice_index  = r_out_idx;
    assign o_res.note_out     = r_out_note;
    assign o_res.velocity_out = r_out_vel;

endmodule

// ----- sv/mva_checker.sv -----
module mva_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [2:0] i_action,
    input logic [2:0] i_voice_index,
    input logic [6:0] i_note_out,
    input logic [6:0] i_velocity_out
);
    import mva_pkg::*;

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_action)
            && $stable(i_note_out))
        else $error("result dropped or changed while stalled");

    // one request in flight at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request taken while previous one still in work");

    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_action == ACT_NONE) |->
            (i_voice_index == 3'd0) && (i_note_out == 7'd0) && (i_velocity_out == 7'd0))
        else $error("ignored event with nonzero fields");

    a_idx_gate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_voice_index != 3'd0) |->
            (i_action == ACT_GATE_ON) || (i_action == ACT_GATE_OFF))
        else $error("voice index on a non-gate action");

endmodule

bind midi_voice_allocator_core mva_checker u_mva_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_req.valid),
    .i_in_ready     (i_req.ready),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_action       (o_res.action),
    .i_voice_index  (o_res.voice_index),
    .i_note_out     (o_res.note_out),
    .i_velocity_out (o_res.velocity_out)
);
